// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
// Needs a clock named clk and a reset named rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/tts_pkg.sv =====
// Types and constants of the tick task scheduler table.
// No dependencies; used by the scheduler table module.
package tts_pkg;

  localparam int SLOTS  = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int ID_W   = 4;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ID_W-1:0]   id_t;
  typedef logic [ID_W:0]     idc_t;
  typedef logic [SLOTS-1:0]  slot_vec_t;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_ADD      = 2'd1,
    ACT_DISPATCH = 2'd2,
    ACT_DELETE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NO_TASK = 2'd2
  } status_e;

  typedef struct packed {
    action_e     action;
    logic [31:0] delay_ticks;
    logic [31:0] period_ticks;
    id_t         task_id;
  } req_t;

  typedef struct packed {
    id_t     task_id_res;
    status_e status;
    logic    last;
  } res_t;

  typedef struct packed {
    logic [31:0] delay;
    logic [31:0] period;
    logic [7:0]  run_count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/core/tts_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module tts_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 72,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/tick_task_scheduler_table.sv =====
// Tick task scheduler table: slot timers in a RAM, walked one slot a cycle unless a dispatch stalls.
// Add and delete: request registered, then result registered from S_ONE once the output is free; one slot lookup.
// Tick and dispatch: read of the next slot overlaps the write-back of the current one;
// dispatch holds while its result waits.
// Next request taken the cycle after the previous one finishes.
// Synchronous reset frees all slots at once; no RAM clearing pass.
`include "assert_macros.svh"

module tick_task_scheduler_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  tts_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output tts_pkg::res_t res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ONE,
    S_WALK
  } state_t;

  state_t              state;
  tts_pkg::req_t       cur;
  tts_pkg::slot_vec_t  used, used_next;
  tts_pkg::slot_vec_t  due, due_next;
  tts_pkg::cnt_t       rd_idx;
  logic                s_vld;
  tts_pkg::slot_t      s_idx;

  logic                ram_we, ram_re;
  tts_pkg::slot_t      ram_waddr, ram_raddr;
  tts_pkg::entry_t     ram_wdata, ram_rdata;

  logic                out_free, stall, step, walk_done;
  logic                emit;
  tts_pkg::res_t       emit_res;
  logic                free_found;
  tts_pkg::slot_t      free_idx;
  logic                due_above;
  logic                id_ok;
  tts_pkg::slot_t      del_idx;
  tts_pkg::entry_t     upd;

  tts_ram #(
    .DEPTH (tts_pkg::SLOTS),
    .WIDTH (tts_pkg::ENTRY_W),
    .AW    (tts_pkg::SLOT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_ready = (state == S_IDLE);
  assign out_free  = !res_valid || res_ready;
  assign stall     = s_vld && (cur.action == tts_pkg::ACT_DISPATCH) && due[s_idx] && !out_free;
  assign step      = (state == S_WALK) && !stall;
  assign walk_done = (rd_idx == tts_pkg::cnt_t'(tts_pkg::SLOTS));
  assign id_ok     = tts_pkg::idc_t'(cur.task_id) < tts_pkg::idc_t'(tts_pkg::SLOTS);
  assign del_idx   = tts_pkg::slot_t'(cur.task_id);
  assign ram_re    = step && !walk_done;
  assign ram_raddr = rd_idx[tts_pkg::SLOT_W-1:0];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = tts_pkg::SLOTS - 1; k >= 0; k--) begin
      if (!used[k]) begin
        free_found = 1'b1;
        free_idx   = tts_pkg::slot_t'(k);
      end
    end
    due_above = 1'b0;
    for (int k = 0; k < tts_pkg::SLOTS; k++) begin
      if (due[k] && (tts_pkg::slot_t'(k) > s_idx)) begin
        due_above = 1'b1;
      end
    end
  end

  always_comb begin
    used_next = used;
    due_next  = due;
    ram_we    = 1'b0;
    ram_waddr = s_idx;
    ram_wdata = ram_rdata;
    upd       = ram_rdata;
    emit      = 1'b0;
    emit_res  = '{task_id_res: '0, status: tts_pkg::ST_OK, last: 1'b1};
    unique case (state)
      S_ONE: begin
        if (out_free) begin
          emit = 1'b1;
          if (cur.action == tts_pkg::ACT_ADD) begin
            if (free_found) begin
              ram_we              = 1'b1;
              ram_waddr           = free_idx;
              ram_wdata           = '{delay: cur.delay_ticks, period: cur.period_ticks,
                                      run_count: 8'd0};
              used_next[free_idx] = 1'b1;
              due_next[free_idx]  = 1'b0;
              emit_res.task_id_res = tts_pkg::id_t'(free_idx);
            end else begin
              emit_res.status = tts_pkg::ST_FULL;
            end
          end else begin
            emit_res.task_id_res = cur.task_id;
            if (id_ok) begin
              used_next[del_idx] = 1'b0;
              due_next[del_idx]  = 1'b0;
              emit_res.status    = used[del_idx] ? tts_pkg::ST_OK : tts_pkg::ST_NO_TASK;
            end else begin
              emit_res.status = tts_pkg::ST_NO_TASK;
            end
          end
        end
      end
      S_WALK: begin
        if (step && s_vld) begin
          if (cur.action == tts_pkg::ACT_TICK) begin
            if (used[s_idx]) begin
              if (ram_rdata.delay == 32'd0) begin
                if (ram_rdata.run_count != 8'hFF) begin
                  upd.run_count = ram_rdata.run_count + 8'd1;
                end
                if (ram_rdata.period != 32'd0) begin
                  upd.delay = ram_rdata.period;
                end
              end else begin
                upd.delay = ram_rdata.delay - 32'd1;
              end
              ram_we          = 1'b1;
              ram_wdata       = upd;
              due_next[s_idx] = (upd.run_count != 8'd0);
            end
          end else if (due[s_idx]) begin
            upd.run_count        = ram_rdata.run_count - 8'd1;
            emit                 = 1'b1;
            emit_res.task_id_res = tts_pkg::id_t'(s_idx);
            emit_res.last        = !due_above;
            if (ram_rdata.period == 32'd0) begin
              used_next[s_idx] = 1'b0;
              due_next[s_idx]  = 1'b0;
            end else begin
              ram_we          = 1'b1;
              ram_wdata       = upd;
              due_next[s_idx] = (upd.run_count != 8'd0);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      due       <= '0;
      rd_idx    <= '0;
      s_vld     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      used <= used_next;
      due  <= due_next;
      if (emit) begin
        res_valid <= 1'b1;
        res       <= emit_res;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur    <= req;
            rd_idx <= '0;
            s_vld  <= 1'b0;
            if ((req.action == tts_pkg::ACT_TICK) || (req.action == tts_pkg::ACT_DISPATCH)) begin
              state <= S_WALK;
            end else begin
              state <= S_ONE;
            end
          end
        end
        S_ONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_WALK: begin
          if (step) begin
            if (walk_done) begin
              s_vld <= 1'b0;
              state <= S_IDLE;
            end else begin
              s_vld  <= 1'b1;
              s_idx  <= rd_idx[tts_pkg::SLOT_W-1:0];
              rd_idx <= rd_idx + tts_pkg::cnt_t'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_due_used, (due & ~used) == '0)
  `ASSERT_ALWAYS(a_rd_bound, rd_idx <= tts_pkg::cnt_t'(tts_pkg::SLOTS))
  `ASSERT_ALWAYS(a_no_rw_clash, !(ram_we && ram_re && (ram_waddr == ram_raddr)))
  `ASSERT_IMPL(a_emit_room, emit, out_free)

endmodule
